>>> design/rtirl_pkg.sv
// Shared types and constants for the region table block.
// No dependencies; imported by region_table_insert_remove_lookup, region_table_monitor and testbench.
package rtirl_pkg;

    localparam int ADDR_W        = 64;
    localparam int LEN_W         = 55;
    localparam int SLOT_W        = 6;
    localparam int CNT_OUT_W     = 7;
    localparam int GROUP_LOG2    = 3;
    localparam int DEFAULT_DEPTH = 64;

    // Action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    // Status codes
    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STS_IGNORED   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXACT,
        ST_RANGE,
        ST_MOVE_RD,
        ST_MOVE_WR
    } t_state;

endpackage

>>> design/region_table_insert_remove_lookup.sv
// Region table top level: start/length entries held in one synchronous memory.
// Depends on rtirl_pkg.
//
// A command is taken when start is high and busy is low; its one result is
// shown on the o_ ports for a single cycle, flagged by o_valid, and cannot be
// held off by the receiver. Insert answers in the cycle after the transfer.
// Remove walks the table one entry per cycle through the single read port of
// the entry memory. Moving the last entry into the freed slot passes through
// ST_MOVE_RD and ST_MOVE_WR after the match, and is needed only when that
// match is not on the last entry. Lookup first walks the complete groups of
// eight looking for an exact start, then the whole table for a containing
// range. The frozen register blocks insert and remove; it is to be written only
// while the block is idle, which the block itself does not enforce.
module region_table_insert_remove_lookup
    import rtirl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_action,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [LEN_W-1:0]     i_length,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_slot_index,
    output logic [ADDR_W-1:0]    o_found_start,
    output logic [LEN_W-1:0]     o_found_length,
    output logic [CNT_OUT_W-1:0] o_entry_count
);

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = ADDR_W + LEN_W;

    // Entry memory: {start, length}
    logic [ENT_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0] r_mem_q;
    logic [IW-1:0]    mem_ra;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    logic [ENT_W-1:0] mem_wd;

    // Control and datapath registers
    t_state             r_state,   n_state;
    logic               r_frozen;
    logic [CW-1:0]      r_count,   n_count;
    logic               r_is_rem,  n_is_rem;
    logic [ADDR_W-1:0]  r_addr,    n_addr;
    logic [CW-1:0]      r_limit,   n_limit;
    logic [CW-1:0]      r_rd_idx,  n_rd_idx;
    logic               r_chk_vld, n_chk_vld;
    logic [IW-1:0]      r_chk_idx, n_chk_idx;
    logic [IW-1:0]      r_hit_idx, n_hit_idx;

    // Result registers
    logic               r_valid,   n_valid;
    logic [1:0]         r_status,  n_status;
    logic               r_hit,     n_hit;
    logic [IW-1:0]      r_slot,    n_slot;
    logic [ADDR_W-1:0]  r_fstart,  n_fstart;
    logic [LEN_W-1:0]   r_flen,    n_flen;

    // Entry under check and compares
    logic [ADDR_W-1:0]  q_start;
    logic [LEN_W-1:0]   q_len;
    logic [ADDR_W-1:0]  q_diff;
    logic               exact_hit;
    logic               range_hit;
    logic               issue;
    logic [CW-1:0]      last_cnt;
    logic [IW+SLOT_W-1:0]    slot_ext;
    logic [CW+CNT_OUT_W-1:0] cnt_ext;

    assign q_start   = r_mem_q[ENT_W-1 -: ADDR_W];
    assign q_len     = r_mem_q[LEN_W-1:0];
    assign q_diff    = r_addr - q_start;
    assign exact_hit = r_chk_vld && (q_start == r_addr);
    assign range_hit = r_chk_vld && (q_start != '0) && (r_addr >= q_start) &&
                       (q_diff < {{(ADDR_W-LEN_W){1'b0}}, q_len});
    assign issue     = (r_rd_idx < r_limit);
    assign last_cnt  = r_count - CW'(1);

    // Memory read address: scan pointer, or last entry during a move
    assign mem_ra = (r_state == ST_MOVE_RD) ? last_cnt[IW-1:0] : r_rd_idx[IW-1:0];

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    // Frozen register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frozen <= 1'b0;
        end else if (i_cfg_we) begin
            r_frozen <= i_cfg_wdata;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_chk_vld <= n_chk_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_is_rem  <= n_is_rem;
        r_addr    <= n_addr;
        r_limit   <= n_limit;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_hit_idx <= n_hit_idx;
        r_status  <= n_status;
        r_hit     <= n_hit;
        r_slot    <= n_slot;
        r_fstart  <= n_fstart;
        r_flen    <= n_flen;
    end

    // Next state and outputs
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_is_rem  = r_is_rem;
        n_addr    = r_addr;
        n_limit   = r_limit;
        n_rd_idx  = r_rd_idx;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_hit_idx = r_hit_idx;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_hit     = r_hit;
        n_slot    = r_slot;
        n_fstart  = r_fstart;
        n_flen    = r_flen;
        mem_we    = 1'b0;
        mem_wa    = r_count[IW-1:0];
        mem_wd    = {i_address, i_length};

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // default result: ignored, all fields zero
                    n_status  = STS_IGNORED;
                    n_hit     = 1'b0;
                    n_slot    = '0;
                    n_fstart  = '0;
                    n_flen    = '0;
                    n_addr    = i_address;
                    n_rd_idx  = '0;
                    n_is_rem  = (i_action == ACT_REMOVE);
                    case (i_action)
                        ACT_INSERT: begin
                            n_valid = 1'b1;
                            if (!r_frozen) begin
                                if (r_count >= CW'(TABLE_DEPTH)) begin
                                    n_status = STS_FULL;
                                end else begin
                                    mem_we   = 1'b1;
                                    n_count  = r_count + CW'(1);
                                    n_status = STS_DONE;
                                    n_slot   = r_count[IW-1:0];
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_frozen || i_address == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_limit = r_count;
                                n_state = ST_EXACT;
                            end
                        end
                        ACT_LOOKUP: begin
                            if (i_address == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                // exact pass covers complete groups of eight only
                                n_limit = {r_count[CW-1:GROUP_LOG2], {GROUP_LOG2{1'b0}}};
                                n_state = ST_EXACT;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            ST_EXACT: begin
                n_chk_vld = issue;
                n_chk_idx = r_rd_idx[IW-1:0];
                n_rd_idx  = r_rd_idx + CW'(issue);
                if (exact_hit) begin
                    n_chk_vld = 1'b0;
                    n_status  = STS_DONE;
                    n_hit     = 1'b1;
                    n_slot    = r_chk_idx;
                    n_fstart  = q_start;
                    n_flen    = q_len;
                    n_hit_idx = r_chk_idx;
                    if (!r_is_rem) begin
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end else if (r_chk_idx == last_cnt[IW-1:0]) begin
                        // removing the last entry: nothing to move
                        n_count = last_cnt;
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_MOVE_RD;
                    end
                end else if (!r_chk_vld && !issue) begin
                    if (r_is_rem) begin
                        n_status = STS_NOT_FOUND;
                        n_valid  = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_chk_vld = 1'b0;
                        n_rd_idx  = '0;
                        n_limit   = r_count;
                        n_state   = ST_RANGE;
                    end
                end
            end

            ST_RANGE: begin
                n_chk_vld = issue;
                n_chk_idx = r_rd_idx[IW-1:0];
                n_rd_idx  = r_rd_idx + CW'(issue);
                if (range_hit) begin
                    n_chk_vld = 1'b0;
                    n_status  = STS_DONE;
                    n_hit     = 1'b1;
                    n_slot    = r_chk_idx;
                    n_fstart  = q_start;
                    n_flen    = q_len;
                    n_valid   = 1'b1;
                    n_state   = ST_IDLE;
                end else if (!r_chk_vld && !issue) begin
                    n_status = STS_NOT_FOUND;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            ST_MOVE_RD: begin
                // last entry is being read out
                n_state = ST_MOVE_WR;
            end

            ST_MOVE_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_hit_idx;
                mem_wd  = r_mem_q;
                n_count = last_cnt;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output ports: slot and count carry their low bits only
    assign slot_ext = {{SLOT_W{1'b0}}, r_slot};
    assign cnt_ext  = {{CNT_OUT_W{1'b0}}, r_count};

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_hit          = r_hit;
    assign o_slot_index   = slot_ext[SLOT_W-1:0];
    assign o_found_start  = r_fstart;
    assign o_found_length = r_flen;
    assign o_entry_count  = cnt_ext[CNT_OUT_W-1:0];

endmodule

>>> verif/region_table_monitor.sv
// Watches the command and result ports of the region table, predicts each reply and compares.
// Depends on rtirl_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps

module region_table_monitor
    import rtirl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [1:0]           i_action,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [LEN_W-1:0]     i_length,
    input  logic                 i_valid,
    input  logic [1:0]           i_status,
    input  logic                 i_hit,
    input  logic [SLOT_W-1:0]    i_slot_index,
    input  logic [ADDR_W-1:0]    i_found_start,
    input  logic [LEN_W-1:0]     i_found_length,
    input  logic [CNT_OUT_W-1:0] i_entry_count,
    output int                   o_failures,
    output int                   o_pending
);

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int GROUP = 1 << GROUP_LOG2;

    typedef struct packed {
        logic [1:0]           status;
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic [ADDR_W-1:0]    base;
        logic [LEN_W-1:0]     size;
        logic [CNT_OUT_W-1:0] count;
    } t_region_reply;

    // Shadow copy of the table and the frozen register
    logic [ADDR_W-1:0] region_base [DEPTH];
    logic [LEN_W-1:0]  region_size [DEPTH];
    int unsigned       live_count;
    logic              frozen_q;

    t_region_reply     pending_replies [$];
    int                mismatches;

    // Applies one command to the shadow table and returns the reply it should give
    function automatic t_region_reply apply_command(logic [1:0] act, logic [ADDR_W-1:0] addr,
                                                    logic [LEN_W-1:0] len);
        t_region_reply r;
        int unsigned   n;
        int unsigned   full_span;
        bit            matched;
        r = '0;
        n = live_count;
        matched = 1'b0;
        case (act)
            ACT_INSERT: begin
                if (frozen_q) begin
                    r.status = STS_IGNORED;
                end else if (n >= DEPTH) begin
                    r.status = STS_FULL;
                end else begin
                    region_base[n] = addr;
                    region_size[n] = len;
                    live_count = n + 1;
                    r.status = STS_DONE;
                    r.slot = SLOT_W'(n);
                end
            end
            ACT_REMOVE: begin
                if (frozen_q || addr == '0) begin
                    r.status = STS_IGNORED;
                end else begin
                    r.status = STS_NOT_FOUND;
                    for (int i = 0; i < n; i++) begin
                        if (!matched && region_base[i] == addr) begin
                            matched = 1'b1;
                            r.status = STS_DONE;
                            r.hit = 1'b1;
                            r.slot = SLOT_W'(i);
                            r.base = region_base[i];
                            r.size = region_size[i];
                            // last entry fills the freed slot
                            region_base[i] = region_base[n-1];
                            region_size[i] = region_size[n-1];
                            live_count = n - 1;
                        end
                    end
                end
            end
            ACT_LOOKUP: begin
                if (addr == '0) begin
                    r.status = STS_IGNORED;
                end else begin
                    r.status = STS_NOT_FOUND;
                    full_span = n - (n % GROUP);
                    // exact start, complete groups of eight only
                    for (int j = 0; j < full_span; j++) begin
                        if (!matched && region_base[j] == addr) begin
                            matched = 1'b1;
                            r.slot = SLOT_W'(j);
                        end
                    end
                    // containing range; zero starts never match
                    for (int j = 0; j < n; j++) begin
                        if (!matched && region_base[j] != '0 && addr >= region_base[j] &&
                            (addr - region_base[j]) < ADDR_W'(region_size[j])) begin
                            matched = 1'b1;
                            r.slot = SLOT_W'(j);
                        end
                    end
                    if (matched) begin
                        r.status = STS_DONE;
                        r.hit = 1'b1;
                        r.base = region_base[r.slot];
                        r.size = region_size[r.slot];
                    end
                end
            end
            default: r.status = STS_IGNORED;
        endcase
        r.count = CNT_OUT_W'(live_count);
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (mismatches < 10)
            $display("%t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
        mismatches++;
    endtask

    // Result side first, then configuration, then the new command transfer
    always @(posedge i_clk) begin
        t_region_reply want;
        if (!i_rst_n) begin
            pending_replies.delete();
            live_count = 0;
            frozen_q = 1'b0;
        end else begin
            if (i_valid) begin
                if (pending_replies.size() == 0) begin
                    note_mismatch("unexpected result", '0, 64'(i_status));
                end else begin
                    want = pending_replies.pop_front();
                    if (i_status !== want.status)
                        note_mismatch("status", 64'(want.status), 64'(i_status));
                    if (i_hit !== want.hit)
                        note_mismatch("hit", 64'(want.hit), 64'(i_hit));
                    if (i_slot_index !== want.slot)
                        note_mismatch("slot_index", 64'(want.slot), 64'(i_slot_index));
                    if (i_found_start !== want.base)
                        note_mismatch("found_start", want.base, i_found_start);
                    if (i_found_length !== want.size)
                        note_mismatch("found_length", 64'(want.size), 64'(i_found_length));
                    if (i_entry_count !== want.count)
                        note_mismatch("entry_count", 64'(want.count), 64'(i_entry_count));
                end
            end
            if (i_cfg_we)
                frozen_q = i_cfg_wdata;
            if (i_start && !i_busy)
                pending_replies.push_back(apply_command(i_action, i_address, i_length));
        end
        o_pending <= pending_replies.size();
        o_failures <= mismatches;
    end

    initial begin
        mismatches = 0;
        live_count = 0;
        frozen_q = 1'b0;
        o_pending = 0;
        o_failures = 0;
    end

endmodule

>>> verif/testbench.sv
// Top of the region table testbench: clock, reset, command stimulus and the verdict.
// Depends on rtirl_pkg, region_table_insert_remove_lookup and region_table_monitor.
`timescale 1ns / 100ps

module testbench;
    import rtirl_pkg::*;

    localparam logic [1:0] ACT_SPARE   = 2'd3;
    localparam int         QUIET_LIMIT = 3000;
    localparam int         POOL_SIZE   = 24;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_wdata;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_action;
    logic [ADDR_W-1:0]    i_address;
    logic [LEN_W-1:0]     i_length;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_slot_index;
    logic [ADDR_W-1:0]    o_found_start;
    logic [LEN_W-1:0]     o_found_length;
    logic [CNT_OUT_W-1:0] o_entry_count;
    int                   failures;
    int                   pending;
    int                   quiet_cycles;
    int                   burst_left;
    logic [ADDR_W-1:0]    base_pool [POOL_SIZE];

    always #5 i_clk = ~i_clk;

    region_table_insert_remove_lookup dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_address      (i_address),
        .i_length       (i_length),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_hit          (o_hit),
        .o_slot_index   (o_slot_index),
        .o_found_start  (o_found_start),
        .o_found_length (o_found_length),
        .o_entry_count  (o_entry_count)
    );

    region_table_monitor monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_address      (i_address),
        .i_length       (i_length),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_hit          (o_hit),
        .i_slot_index   (o_slot_index),
        .i_found_start  (o_found_start),
        .i_found_length (o_found_length),
        .i_entry_count  (o_entry_count),
        .o_failures     (failures),
        .o_pending      (pending)
    );

    // Watchdog: cycles with neither a command nor a result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Region starts: mostly from the shared pool so removes and lookups find them
    function automatic logic [ADDR_W-1:0] pick_start();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return base_pool[$urandom_range(0, POOL_SIZE-1)];
            6, 7:             return rand64();
            8:                return {56'hFF_FFFF_FFFF_FFFF, 8'($urandom)};
            default:          return ADDR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return LEN_W'($urandom_range(0, 768));
            7:                   return {LEN_W{1'b1}};
            8:                   return LEN_W'(rand64());
            default:             return '0;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_query();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return base_pool[$urandom_range(0, POOL_SIZE-1)] +
                                  ADDR_W'($urandom_range(0, 800));
            5, 6:          return base_pool[$urandom_range(0, POOL_SIZE-1)];
            7:             return '0;
            8:             return rand64();
            default:       return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_victim();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return base_pool[$urandom_range(0, POOL_SIZE-1)];
            7:                   return '0;
            default:             return rand64();
        endcase
    endfunction

    // One command transfer, paced in bursts with random gaps between them
    task automatic issue(logic [1:0] act, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1;
        i_action <= act;
        i_address <= addr;
        i_length <= len;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off until every reply has come and the block is idle
    task automatic settle();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic set_frozen(logic value);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int items, int ins_pct, int rem_pct, int look_pct);
        int roll;
        for (int k = 0; k < items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                issue(ACT_INSERT, pick_start(), pick_length());
            else if (roll < ins_pct + rem_pct)
                issue(ACT_REMOVE, pick_victim(), LEN_W'(rand64()));
            else if (roll < ins_pct + rem_pct + look_pct)
                issue(ACT_LOOKUP, pick_query(), LEN_W'(rand64()));
            else
                issue(ACT_SPARE, rand64(), LEN_W'(rand64()));
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        start <= 1'b0;
        i_action <= ACT_INSERT;
        i_address <= '0;
        i_length <= '0;
        quiet_cycles = 0;
        burst_left = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            base_pool[i] = (i < 8) ? ADDR_W'(64'h1000 * (i + 1)) : rand64() | 64'h1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, zero addresses and the spare action code
        issue(ACT_LOOKUP, 64'h1, '0);
        issue(ACT_LOOKUP, '0, '0);
        issue(ACT_REMOVE, '0, '0);
        issue(ACT_REMOVE, 64'h5, {LEN_W{1'b1}});
        issue(ACT_SPARE, {ADDR_W{1'b1}}, {LEN_W{1'b1}});
        // zero start is stored but never matched by range
        issue(ACT_INSERT, '0, {LEN_W{1'b1}});
        issue(ACT_LOOKUP, 64'h5, '0);
        // top of the address space: range end past 2^64 must not wrap
        issue(ACT_INSERT, {ADDR_W{1'b1}}, {LEN_W{1'b1}});
        issue(ACT_LOOKUP, {ADDR_W{1'b1}}, '0);
        issue(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 55'h10);
        issue(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFF8, '0);
        // zero-length entry in a partial group: no exact hit, then a covering range
        issue(ACT_INSERT, 64'h1000, '0);
        issue(ACT_LOOKUP, 64'h1000, '0);
        issue(ACT_INSERT, 64'h0800, 55'h1000);
        issue(ACT_LOOKUP, 64'h1000, '0);
        // complete the first group of eight: the exact start now wins
        issue(ACT_INSERT, 64'h2000, 55'h1);
        issue(ACT_INSERT, 64'h1000, 55'h5);
        issue(ACT_INSERT, rand64(), LEN_W'(rand64()));
        issue(ACT_LOOKUP, 64'h1000, '0);
        issue(ACT_REMOVE, 64'h0800, '0);
        issue(ACT_REMOVE, 64'h1000, '0);
        // frozen blocks insert and remove only
        set_frozen(1'b1);
        issue(ACT_INSERT, 64'h3000, 55'h40);
        issue(ACT_REMOVE, {ADDR_W{1'b1}}, '0);
        issue(ACT_LOOKUP, {ADDR_W{1'b1}}, '0);
        set_frozen(1'b0);

        // Random part: fill to full, churn, frozen, drain, churn, drain
        run_phase(250, 70, 5, 22);
        run_phase(300, 35, 30, 32);
        set_frozen(1'b1);
        run_phase(150, 15, 15, 67);
        set_frozen(1'b0);
        run_phase(200, 10, 60, 27);
        run_phase(200, 45, 25, 27);
        run_phase(150, 5, 70, 22);

        settle();
        repeat (150) @(posedge i_clk);
        if (failures == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
